/* src/sug_pkg.sv */
// Package for the sequenced update gate: operation and outcome codes,
// the table update command and the result word layout.
// No dependencies.
package sug_pkg;

	localparam int TOTAL_W = 32;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		OUT_ACCEPTED    = 3'd0,
		OUT_UNSUPPORTED = 3'd1,
		OUT_INVALID     = 3'd2,
		OUT_OLDER_TIME  = 3'd3,
		OUT_STALE_SEQ   = 3'd4,
		OUT_CLEARED     = 3'd5
	} outcome_t;

	// Write strobes from the gate logic to the table.
	typedef struct packed {
		logic clear;
		logic store;
		logic count_wr;
	} upd_t;

	typedef struct packed {
		logic               accepted;
		outcome_t           outcome;
		logic [63:0]        entry_version;
		logic [TOTAL_W-1:0] accepted_total;
		logic [TOTAL_W-1:0] rejected_total;
		logic [TOTAL_W-1:0] out_of_order_total;
		logic [63:0]        held_value;
		logic [63:0]        held_time;
	} result_t;

endpackage

/* src/sequenced_update_gate.sv */
// Sequenced update gate: per-symbol table of the latest accepted update
// with order checks and saturating counters. Depends on sug_pkg,
// sug_check and sug_table.
//
// Usage:
//   Drive an update or clear word on the input ports with start high; it
//   is taken at the rising edge where start is high and busy is low. busy
//   stays low, so a word may be presented every cycle.
//   The word is registered, classified against its table entry in the
//   next cycle while the table is written, and its result is registered.
//   done is registered from the valid bit of the input register and is
//   high for exactly one cycle with the result fields; the result is taken
//   at the edge that ends that cycle. Throughput is one word per cycle:
//   the table entry is read and written within the single gate stage, so
//   each word sees the effect of the word before it.
//   The receiver cannot stall; each result must be taken in its cycle.
//   Reset clears the table, the counters, the global version and any
//   word in flight.
module sequenced_update_gate import sug_pkg::*; #(
	parameter int NUM_SYMBOLS = 2,
	parameter int COUNT_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [1:0]         symbol_code,
	input  logic signed [63:0] factor_value,
	input  logic [63:0]        event_time,
	input  logic [63:0]        receive_time,
	input  logic [63:0]        seq_number,
	output logic               done,
	output logic               accepted,
	output logic [2:0]         outcome,
	output logic [63:0]        entry_version,
	output logic [31:0]        accepted_total,
	output logic [31:0]        rejected_total,
	output logic [31:0]        out_of_order_total,
	output logic signed [63:0] held_value,
	output logic [63:0]        held_time
);

	localparam int IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

	logic                   valid_s1;
	logic                   op_s1;
	logic [1:0]             code_s1;
	logic [63:0]            value_s1;
	logic [63:0]            time_s1;
	logic [63:0]            receive_s1;
	logic [63:0]            seq_s1;

	logic                   done_s2;
	result_t                res_s2;

	logic [IDX_W-1:0]       rd_idx;
	logic [63:0]            rd_value;
	logic [63:0]            rd_time;
	logic [63:0]            rd_seq;
	logic [COUNT_WIDTH-1:0] rd_acc;
	logic [COUNT_WIDTH-1:0] rd_rej;
	logic [COUNT_WIDTH-1:0] rd_ord;
	logic [63:0]            gver;
	upd_t                   upd;
	logic [63:0]            wr_version;
	logic [COUNT_WIDTH-1:0] wr_acc;
	logic [COUNT_WIDTH-1:0] wr_rej;
	logic [COUNT_WIDTH-1:0] wr_ord;
	result_t                res;
	logic                   take;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1      <= operation;
			code_s1    <= symbol_code;
			value_s1   <= factor_value;
			time_s1    <= event_time;
			receive_s1 <= receive_time;
			seq_s1     <= seq_number;
		end
	end

	sug_check #(
		.NUM_SYMBOLS(NUM_SYMBOLS),
		.COUNT_WIDTH(COUNT_WIDTH),
		.IDX_W      (IDX_W)
	) u_check (
		.valid         (valid_s1),
		.operation     (op_s1),
		.symbol_code   (code_s1),
		.factor_value  (value_s1),
		.event_time    (time_s1),
		.receive_time  (receive_s1),
		.seq_number    (seq_s1),
		.rd_idx        (rd_idx),
		.rd_value      (rd_value),
		.rd_time       (rd_time),
		.rd_seq        (rd_seq),
		.rd_acc        (rd_acc),
		.rd_rej        (rd_rej),
		.rd_ord        (rd_ord),
		.global_version(gver),
		.upd           (upd),
		.wr_version    (wr_version),
		.wr_acc        (wr_acc),
		.wr_rej        (wr_rej),
		.wr_ord        (wr_ord),
		.res           (res)
	);

	sug_table #(
		.NUM_SYMBOLS(NUM_SYMBOLS),
		.COUNT_WIDTH(COUNT_WIDTH),
		.IDX_W      (IDX_W)
	) u_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_idx        (rd_idx),
		.rd_value      (rd_value),
		.rd_time       (rd_time),
		.rd_seq        (rd_seq),
		.rd_acc        (rd_acc),
		.rd_rej        (rd_rej),
		.rd_ord        (rd_ord),
		.global_version(gver),
		.upd           (upd),
		.wr_idx        (rd_idx),
		.wr_value      (value_s1),
		.wr_time       (time_s1),
		.wr_receive    (receive_s1),
		.wr_seq        (seq_s1),
		.wr_version    (wr_version),
		.wr_acc        (wr_acc),
		.wr_rej        (wr_rej),
		.wr_ord        (wr_ord)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res;
		end
	end

	assign done               = done_s2;
	assign accepted           = res_s2.accepted;
	assign outcome            = res_s2.outcome;
	assign entry_version      = res_s2.entry_version;
	assign accepted_total     = res_s2.accepted_total;
	assign rejected_total     = res_s2.rejected_total;
	assign out_of_order_total = res_s2.out_of_order_total;
	assign held_value         = res_s2.held_value;
	assign held_time          = res_s2.held_time;

endmodule

/* src/sug_table.sv */
// Per-symbol entry table and global version register of the update gate.
// Depends on sug_pkg for the update command struct.
module sug_table import sug_pkg::*; #(
	parameter int NUM_SYMBOLS = 2,
	parameter int COUNT_WIDTH = 32,
	parameter int IDX_W       = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IDX_W-1:0]       rd_idx,
	output logic [63:0]            rd_value,
	output logic [63:0]            rd_time,
	output logic [63:0]            rd_seq,
	output logic [COUNT_WIDTH-1:0] rd_acc,
	output logic [COUNT_WIDTH-1:0] rd_rej,
	output logic [COUNT_WIDTH-1:0] rd_ord,
	output logic [63:0]            global_version,
	input  upd_t                   upd,
	input  logic [IDX_W-1:0]       wr_idx,
	input  logic [63:0]            wr_value,
	input  logic [63:0]            wr_time,
	input  logic [63:0]            wr_receive,
	input  logic [63:0]            wr_seq,
	input  logic [63:0]            wr_version,
	input  logic [COUNT_WIDTH-1:0] wr_acc,
	input  logic [COUNT_WIDTH-1:0] wr_rej,
	input  logic [COUNT_WIDTH-1:0] wr_ord
);

	logic [63:0]            value_q   [NUM_SYMBOLS];
	logic [63:0]            time_q    [NUM_SYMBOLS];
	logic [63:0]            receive_q [NUM_SYMBOLS];
	logic [63:0]            seq_q     [NUM_SYMBOLS];
	logic [63:0]            version_q [NUM_SYMBOLS];
	logic [COUNT_WIDTH-1:0] acc_q     [NUM_SYMBOLS];
	logic [COUNT_WIDTH-1:0] rej_q     [NUM_SYMBOLS];
	logic [COUNT_WIDTH-1:0] ord_q     [NUM_SYMBOLS];
	logic [63:0]            gver_q;
	logic                   rd_ok;

	assign rd_ok = {1'b0, rd_idx} < (IDX_W+1)'(NUM_SYMBOLS);

	always_comb begin
		rd_value = '0;
		rd_time  = '0;
		rd_seq   = '0;
		rd_acc   = '0;
		rd_rej   = '0;
		rd_ord   = '0;
		if (rd_ok) begin
			rd_value = value_q[rd_idx];
			rd_time  = time_q[rd_idx];
			rd_seq   = seq_q[rd_idx];
			rd_acc   = acc_q[rd_idx];
			rd_rej   = rej_q[rd_idx];
			rd_ord   = ord_q[rd_idx];
		end
	end

	assign global_version = gver_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gver_q <= '0;
			for (int i = 0; i < NUM_SYMBOLS; i++) begin
				value_q[i]   <= '0;
				time_q[i]    <= '0;
				receive_q[i] <= '0;
				seq_q[i]     <= '0;
				version_q[i] <= '0;
				acc_q[i]     <= '0;
				rej_q[i]     <= '0;
				ord_q[i]     <= '0;
			end
		end else if (upd.clear) begin
			gver_q <= wr_version;
			for (int i = 0; i < NUM_SYMBOLS; i++) begin
				value_q[i]   <= '0;
				time_q[i]    <= '0;
				receive_q[i] <= '0;
				seq_q[i]     <= '0;
				version_q[i] <= '0;
				acc_q[i]     <= '0;
				rej_q[i]     <= '0;
				ord_q[i]     <= '0;
			end
		end else begin
			if (upd.store) begin
				gver_q             <= wr_version;
				value_q[wr_idx]    <= wr_value;
				time_q[wr_idx]     <= wr_time;
				receive_q[wr_idx]  <= wr_receive;
				seq_q[wr_idx]      <= wr_seq;
				version_q[wr_idx]  <= wr_version;
			end
			if (upd.count_wr) begin
				acc_q[wr_idx] <= wr_acc;
				rej_q[wr_idx] <= wr_rej;
				ord_q[wr_idx] <= wr_ord;
			end
		end
	end

endmodule

/* src/sug_check.sv */
// Gate logic of the update gate: classifies one word against its table
// entry and builds the table writes and the result. Depends on sug_pkg.
module sug_check import sug_pkg::*; #(
	parameter int NUM_SYMBOLS = 2,
	parameter int COUNT_WIDTH = 32,
	parameter int IDX_W       = 1
) (
	input  logic                   valid,
	input  logic                   operation,
	input  logic [1:0]             symbol_code,
	input  logic [63:0]            factor_value,
	input  logic [63:0]            event_time,
	input  logic [63:0]            receive_time,
	input  logic [63:0]            seq_number,
	output logic [IDX_W-1:0]       rd_idx,
	input  logic [63:0]            rd_value,
	input  logic [63:0]            rd_time,
	input  logic [63:0]            rd_seq,
	input  logic [COUNT_WIDTH-1:0] rd_acc,
	input  logic [COUNT_WIDTH-1:0] rd_rej,
	input  logic [COUNT_WIDTH-1:0] rd_ord,
	input  logic [63:0]            global_version,
	output upd_t                   upd,
	output logic [63:0]            wr_version,
	output logic [COUNT_WIDTH-1:0] wr_acc,
	output logic [COUNT_WIDTH-1:0] wr_rej,
	output logic [COUNT_WIDTH-1:0] wr_ord,
	output result_t                res
);

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + COUNT_WIDTH'(1);
	endfunction

	function automatic logic [TOTAL_W-1:0] to_total(input logic [COUNT_WIDTH-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return w[TOTAL_W-1:0];
	endfunction

	logic [4:0]  code_ext;
	logic        supported;
	logic        invalid;
	logic        has_entry;
	logic        older;
	logic        stale;
	logic [63:0] version_inc;

	assign code_ext    = 5'(symbol_code);
	assign supported   = code_ext < 5'(NUM_SYMBOLS);
	assign rd_idx      = code_ext[IDX_W-1:0];
	assign invalid     = factor_value[63] || (factor_value == '0) ||
	                     (event_time == '0) || (receive_time == '0);
	assign has_entry   = rd_time != '0;
	assign older       = has_entry && (event_time < rd_time);
	assign stale       = has_entry && (seq_number != '0) && (rd_seq != '0) &&
	                     (seq_number <= rd_seq);
	assign version_inc = global_version + 64'd1;
	assign wr_version  = version_inc;

	always_comb begin
		upd    = '0;
		wr_acc = rd_acc;
		wr_rej = rd_rej;
		wr_ord = rd_ord;

		res                    = '0;
		res.outcome            = OUT_ACCEPTED;
		res.entry_version      = global_version;
		res.accepted_total     = to_total(rd_acc);
		res.rejected_total     = to_total(rd_rej);
		res.out_of_order_total = to_total(rd_ord);
		res.held_value         = rd_value;
		res.held_time          = rd_time;

		if (operation == OP_CLEAR) begin
			upd.clear              = valid;
			res.outcome            = OUT_CLEARED;
			res.entry_version      = version_inc;
			res.accepted_total     = '0;
			res.rejected_total     = '0;
			res.out_of_order_total = '0;
			res.held_value         = '0;
			res.held_time          = '0;
		end else if (!supported) begin
			res.outcome            = OUT_UNSUPPORTED;
			res.accepted_total     = '0;
			res.rejected_total     = '0;
			res.out_of_order_total = '0;
			res.held_value         = '0;
			res.held_time          = '0;
		end else if (invalid) begin
			upd.count_wr       = valid;
			wr_rej             = sat_inc(rd_rej);
			res.outcome        = OUT_INVALID;
			res.rejected_total = to_total(wr_rej);
		end else if (older || stale) begin
			upd.count_wr           = valid;
			wr_rej                 = sat_inc(rd_rej);
			wr_ord                 = sat_inc(rd_ord);
			res.outcome            = older ? OUT_OLDER_TIME : OUT_STALE_SEQ;
			res.rejected_total     = to_total(wr_rej);
			res.out_of_order_total = to_total(wr_ord);
		end else begin
			upd.store          = valid;
			upd.count_wr       = valid;
			wr_acc             = sat_inc(rd_acc);
			res.accepted       = 1'b1;
			res.entry_version  = version_inc;
			res.accepted_total = to_total(wr_acc);
			res.held_value     = factor_value;
			res.held_time      = event_time;
		end
	end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for sequenced_update_gate: a scoreboard class predicts
// the result of every accepted word, and plain tasks drive directed and random words.
// Depends on sug_pkg and the sequenced_update_gate RTL.
`timescale 1ns / 1ps

module testbench;
	import sug_pkg::*;

	localparam int NUM_SYM        = 2;
	localparam int RANDOM_WORDS   = 1550;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int PAUSE_AT       = 775;

	class gate_scoreboard;
		bit signed [63:0] held_val[NUM_SYM];
		bit [63:0]        held_ts[NUM_SYM];
		bit [63:0]        held_seq[NUM_SYM];
		bit [31:0]        cnt_acc[NUM_SYM];
		bit [31:0]        cnt_rej[NUM_SYM];
		bit [31:0]        cnt_ooo[NUM_SYM];
		bit [63:0]        version;
		result_t          due_results[$];
		int               errors;
		int               words;
		int               stores;
		int               clears;

		function bit [31:0] bump(bit [31:0] c);
			return (c == '1) ? c : c + 1;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Update the table copy with one accepted word and queue its result.
		function void apply_word(op_t op, bit [1:0] sym, bit signed [63:0] val,
				bit [63:0] ts, bit [63:0] rx, bit [63:0] seq);
			result_t r;
			int      s;
			r = '0;
			words++;
			if (op == OP_CLEAR) begin
				for (int i = 0; i < NUM_SYM; i++) begin
					held_val[i] = 0;
					held_ts[i]  = 0;
					held_seq[i] = 0;
					cnt_acc[i]  = 0;
					cnt_rej[i]  = 0;
					cnt_ooo[i]  = 0;
				end
				version++;
				clears++;
				r.outcome       = OUT_CLEARED;
				r.entry_version = version;
			end else if (sym >= NUM_SYM) begin
				r.outcome       = OUT_UNSUPPORTED;
				r.entry_version = version;
			end else begin
				s = sym;
				if (val <= 0 || ts == 0 || rx == 0) begin
					cnt_rej[s] = bump(cnt_rej[s]);
					r.outcome  = OUT_INVALID;
				end else if (held_ts[s] != 0 && ts < held_ts[s]) begin
					cnt_rej[s] = bump(cnt_rej[s]);
					cnt_ooo[s] = bump(cnt_ooo[s]);
					r.outcome  = OUT_OLDER_TIME;
				end else if (held_ts[s] != 0 && seq != 0 && held_seq[s] != 0
						&& seq <= held_seq[s]) begin
					cnt_rej[s] = bump(cnt_rej[s]);
					cnt_ooo[s] = bump(cnt_ooo[s]);
					r.outcome  = OUT_STALE_SEQ;
				end else begin
					held_val[s] = val;
					held_ts[s]  = ts;
					held_seq[s] = seq;
					cnt_acc[s]  = bump(cnt_acc[s]);
					version++;
					stores++;
					r.accepted = 1'b1;
					r.outcome  = OUT_ACCEPTED;
				end
				r.entry_version      = version;
				r.accepted_total     = cnt_acc[s];
				r.rejected_total     = cnt_rej[s];
				r.out_of_order_total = cnt_ooo[s];
				r.held_value         = held_val[s];
				r.held_time          = held_ts[s];
			end
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic acc, logic [2:0] oc, logic [63:0] ver,
				logic [31:0] at, logic [31:0] rt, logic [31:0] ot,
				logic [63:0] hv, logic [63:0] ht);
			result_t want;
			if (due_results.size() == 0) begin
				$error("result strobe with no word outstanding");
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare_field("accepted", want.accepted, acc);
			compare_field("outcome", want.outcome, oc);
			compare_field("entry_version", want.entry_version, ver);
			compare_field("accepted_total", want.accepted_total, at);
			compare_field("rejected_total", want.rejected_total, rt);
			compare_field("out_of_order_total", want.out_of_order_total, ot);
			compare_field("held_value", want.held_value, hv);
			compare_field("held_time", want.held_time, ht);
		endfunction
	endclass

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic               operation    = 1'b0;
	logic [1:0]         symbol_code  = '0;
	logic signed [63:0] factor_value = '0;
	logic [63:0]        event_time   = '0;
	logic [63:0]        receive_time = '0;
	logic [63:0]        seq_number   = '0;
	logic               busy;
	logic               done;
	logic               accepted;
	logic [2:0]         outcome;
	logic [63:0]        entry_version;
	logic [31:0]        accepted_total;
	logic [31:0]        rejected_total;
	logic [31:0]        out_of_order_total;
	logic signed [63:0] held_value;
	logic [63:0]        held_time;

	gate_scoreboard sb = new();
	int             idle_cycles = 0;

	sequenced_update_gate u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.operation          (operation),
		.symbol_code        (symbol_code),
		.factor_value       (factor_value),
		.event_time         (event_time),
		.receive_time       (receive_time),
		.seq_number         (seq_number),
		.done               (done),
		.accepted           (accepted),
		.outcome            (outcome),
		.entry_version      (entry_version),
		.accepted_total     (accepted_total),
		.rejected_total     (rejected_total),
		.out_of_order_total (out_of_order_total),
		.held_value         (held_value),
		.held_time          (held_time)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(accepted, outcome, entry_version, accepted_total,
				rejected_total, out_of_order_total, held_value, held_time);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Called at a rising edge; returns at the edge that takes the word.
	task automatic send_word(op_t op, bit [1:0] sym, bit [63:0] val, bit [63:0] ts,
			bit [63:0] rx, bit [63:0] seq, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		operation    <= op;
		symbol_code  <= sym;
		factor_value <= val;
		event_time   <= ts;
		receive_time <= rx;
		seq_number   <= seq;
		do @(posedge clk); while (busy);
		sb.apply_word(op, sym, val, ts, rx, seq);
	endtask

	// Hold off new words until every outstanding result is back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic bit [63:0] rand_positive();
		bit [63:0] v;
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(1, 1000);
		v = {$urandom, $urandom};
		v[63] = 1'b0;
		if (v == 0)
			v = 1;
		return v;
	endfunction

	function automatic bit [63:0] rand_nonzero();
		bit [63:0] v;
		v = {$urandom, $urandom};
		return (v == 0) ? 64'd1 : v;
	endfunction

	// Mostly in-order updates built on the predicted entry, plus noise and broken ones.
	task automatic random_word(int gap);
		int        pick;
		bit [1:0]  sym;
		bit [63:0] val, ts, rx, seq, base, sbase, span;
		op_t       op;
		pick  = $urandom_range(0, 99);
		op    = OP_UPDATE;
		sym   = $urandom_range(0, NUM_SYM - 1);
		val   = rand_positive();
		rx    = rand_nonzero();
		base  = sb.held_ts[sym];
		sbase = sb.held_seq[sym];
		ts    = {$urandom, $urandom};
		seq   = {$urandom, $urandom};
		if (pick < 2) begin
			op  = OP_CLEAR;
			sym = $urandom_range(0, 3);
			val = {$urandom, $urandom};
		end else if (pick < 5) begin
			sym = $urandom_range(NUM_SYM, 3);
		end else if (pick < 15) begin
			sym = $urandom_range(0, 3);
			val = {$urandom, $urandom};
			rx  = {$urandom, $urandom};
			if ($urandom_range(0, 3) == 0)
				ts = 0;
			if ($urandom_range(0, 3) == 0)
				rx = 0;
		end else if (pick < 25) begin
			if (base > 1 && $urandom_range(0, 1) == 0) begin
				span = {$urandom, $urandom} % (base - 1);
				ts   = base - 1 - span;
			end else begin
				ts  = (base == 0) ? $urandom_range(1, 100) : base;
				seq = (sbase >= 2) ? sbase - $urandom_range(0, 2) : rand_nonzero();
			end
		end else begin
			ts = base + $urandom_range(0, 40);
			if ($urandom_range(0, 19) == 0)
				ts = base + ({$urandom, $urandom} >> $urandom_range(1, 63));
			if (ts < base)
				ts = base;
			if (ts == 0)
				ts = $urandom_range(1, 40);
			if ($urandom_range(0, 9) == 0 || sbase > 64'hFFFF_FFFF_FFFF_FFF0)
				seq = 0;
			else
				seq = sbase + $urandom_range(1, 3);
		end
		send_word(op, sym, val, ts, rx, seq, gap);
	endtask

	initial begin
		bit [63:0] max_pos;
		bit [63:0] all_ones;
		bit        burst;
		max_pos  = 64'h7FFF_FFFF_FFFF_FFFF;
		all_ones = '1;
		burst    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: clear on empty table, first stores, unsupported codes,
		// invalid value and times, both order rejections, absent sequence.
		send_word(OP_CLEAR, 2'd1, 64'd5, 64'd5, 64'd5, 64'd5, 0);
		send_word(OP_UPDATE, 2'd0, 64'd100, 64'd1000, 64'd1, 64'd10, 0);
		send_word(OP_UPDATE, 2'd1, max_pos, all_ones, all_ones, all_ones, 1);
		send_word(OP_UPDATE, 2'd2, 64'd7, 64'd2000, 64'd1, 64'd20, 0);
		send_word(OP_UPDATE, 2'd3, 64'd7, 64'd2000, 64'd1, 64'd20, 2);
		send_word(OP_UPDATE, 2'd0, 64'd0, 64'd2000, 64'd1, 64'd20, 0);
		send_word(OP_UPDATE, 2'd0, all_ones, 64'd2000, 64'd1, 64'd20, 0);
		send_word(OP_UPDATE, 2'd0, 64'h8000_0000_0000_0000, 64'd2000, 64'd1, 64'd20, 1);
		send_word(OP_UPDATE, 2'd0, 64'd7, 64'd0, 64'd1, 64'd20, 0);
		send_word(OP_UPDATE, 2'd0, 64'd7, 64'd2000, 64'd0, 64'd20, 0);
		send_word(OP_UPDATE, 2'd0, 64'd7, 64'd999, 64'd1, 64'd20, 3);
		send_word(OP_UPDATE, 2'd0, 64'd7, 64'd1000, 64'd1, 64'd10, 0);
		send_word(OP_UPDATE, 2'd0, 64'd7, 64'd1000, 64'd1, 64'd9, 0);
		send_word(OP_UPDATE, 2'd0, 64'd8, 64'd1000, 64'd1, 64'd0, 0);
		send_word(OP_UPDATE, 2'd0, 64'd9, 64'd1001, 64'd1, 64'd5, 2);
		send_word(OP_UPDATE, 2'd0, 64'd1, 64'd1001, all_ones, 64'd6, 0);
		send_word(OP_UPDATE, 2'd1, 64'd3, 64'd5, 64'd1, 64'd1, 0);
		send_word(OP_UPDATE, 2'd1, 64'd3, all_ones, 64'd1, all_ones, 0);
		send_word(OP_UPDATE, 2'd1, 64'd4, all_ones, 64'd1, 64'd0, 1);
		send_word(OP_CLEAR, 2'd3, all_ones, all_ones, all_ones, all_ones, 0);
		send_word(OP_UPDATE, 2'd1, 64'd3, 64'd5, 64'd1, 64'd1, 0);
		send_word(OP_UPDATE, 2'd0, 64'd2, 64'd1, 64'd1, 64'd1, 0);
		send_word(OP_CLEAR, 2'd0, 64'd0, 64'd0, 64'd0, 64'd0, 0);
		drain_results();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 50 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (i == PAUSE_AT)
				drain_results();
			random_word(burst ? 0 : $urandom_range(0, 9));
		end

		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Covered %0d words: %0d stored updates, %0d table clears, the rest refused",
			sb.words, sb.stores, sb.clears);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
src/sug_pkg.sv
src/sug_table.sv
src/sug_check.sv
src/sequenced_update_gate.sv
sim/testbench.sv
